@@ rtl/gmd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the grid maze depth-first path search.
// No dependencies; every other file of the block imports this package.
package gmd_pkg;

	// Fixed widths of the item and register fields
	localparam int FUNC_W    = 2;
	localparam int COORD_W   = 6;
	localparam int IDX_W     = 12;
	localparam int LEN_W     = 13;
	localparam int GRID_W    = 7;
	localparam int CFG_IDX_W = 2;
	// Grid dimension width, wide enough for the largest store (256)
	localparam int DIM_W     = 9;

	// Default store size
	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;
	localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(64);

	// Visit epoch tag; zero marks a cell that no search has touched
	localparam int EPOCH_W = 4;

	// Function codes
	localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_NOP    = 2'd3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;

	// Direction codes, tried in this order
	localparam int DIR_W = 3;
	localparam logic [DIR_W-1:0] DIR_EAST  = 3'd0;
	localparam logic [DIR_W-1:0] DIR_SOUTH = 3'd1;
	localparam logic [DIR_W-1:0] DIR_WEST  = 3'd2;
	localparam logic [DIR_W-1:0] DIR_NORTH = 3'd3;
	localparam logic [DIR_W-1:0] DIR_DONE  = 3'd4;

	typedef enum logic [3:0] {
		S_SWEEP,
		S_IDLE,
		S_PATH,
		S_BEGIN,
		S_RD_TGT,
		S_CHK,
		S_STEP,
		S_PROBE,
		S_POP,
		S_DONE
	} gmd_state_t;

	// Write strobes of the cell store
	typedef struct packed {
		logic maze_we;
		logic maze_wbit;
		logic visit_we;
	} cell_ctl_t;

	// Write strobes of the path stack
	typedef struct packed {
		logic pos_we;
		logic dir_we;
	} stk_ctl_t;

endpackage

@@ rtl/gmd_cell_store.sv @@
`timescale 1ns / 1ps
// Maze wall bits and per-cell visit epoch tags, one synchronous memory each.
// Depends on gmd_pkg.
module gmd_cell_store #(
	parameter int AW    = 12,
	parameter int DEPTH = 4096
) (
	input  logic                      clk,
	input  gmd_pkg::cell_ctl_t        ctl,
	input  logic [AW-1:0]             waddr,
	input  logic [gmd_pkg::EPOCH_W-1:0] visit_wdata,
	input  logic [AW-1:0]             raddr,
	output logic                      maze_rdata,
	output logic [gmd_pkg::EPOCH_W-1:0] visit_rdata
);
	import gmd_pkg::*;

	logic               maze_mem  [DEPTH];
	logic [EPOCH_W-1:0] visit_mem [DEPTH];

	// Write wall bits; the read is registered
	always_ff @(posedge clk) begin
		if (ctl.maze_we) begin
			maze_mem[waddr] <= ctl.maze_wbit;
		end
		maze_rdata <= maze_mem[raddr];
	end

	// Write visit tags; the read is registered
	always_ff @(posedge clk) begin
		if (ctl.visit_we) begin
			visit_mem[waddr] <= visit_wdata;
		end
		visit_rdata <= visit_mem[raddr];
	end

endmodule

@@ rtl/gmd_path_stack.sv @@
`timescale 1ns / 1ps
// Search stack: cell position and next direction of each entry, in two memories.
// Depends on gmd_pkg.
module gmd_path_stack #(
	parameter int RW    = 6,
	parameter int CW    = 6,
	parameter int SAW   = 12,
	parameter int CELLS = 4096
) (
	input  logic                      clk,
	input  gmd_pkg::stk_ctl_t         ctl,
	input  logic [SAW-1:0]            pos_waddr,
	input  logic [RW-1:0]             pos_wrow,
	input  logic [CW-1:0]             pos_wcol,
	input  logic [SAW-1:0]            dir_waddr,
	input  logic [gmd_pkg::DIR_W-1:0] dir_wdata,
	input  logic [SAW-1:0]            raddr,
	output logic [RW-1:0]             rd_row,
	output logic [CW-1:0]             rd_col,
	output logic [gmd_pkg::DIR_W-1:0] rd_dir
);
	import gmd_pkg::*;

	logic [RW+CW-1:0] pos_mem [CELLS];
	logic [DIR_W-1:0] dir_mem [CELLS];

	// Position of each entry
	always_ff @(posedge clk) begin
		if (ctl.pos_we) begin
			pos_mem[pos_waddr] <= {pos_wrow, pos_wcol};
		end
		{rd_row, rd_col} <= pos_mem[raddr];
	end

	// Saved direction of each entry below the top
	always_ff @(posedge clk) begin
		if (ctl.dir_we) begin
			dir_mem[dir_waddr] <= dir_wdata;
		end
		rd_dir <= dir_mem[raddr];
	end

endmodule

@@ rtl/grid_maze_dfs_path_search.sv @@
`timescale 1ns / 1ps
// Grid maze depth-first path search. Cell writes and no-op items are answered
// straight from idle, a path read after one read of the stack memory. A search
// first reads the start and target cells, then for every cell it enters tries up
// to four neighbors, each out of range or probed with a read of the cell store,
// and pops the stack when all directions are spent. Visit marks are epoch tags:
// after reset, and after every fifteen searches, a clearing pass walks all
// MAX_ROWS * 2^clog2(MAX_COLS) entries of the tag memory (4096 by default), one
// entry a cycle, while no item is accepted. Configuration is always accepted.
module grid_maze_dfs_path_search #(
	parameter int MAX_ROWS = gmd_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = gmd_pkg::DEF_MAX_COLS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gmd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gmd_pkg::GRID_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [gmd_pkg::FUNC_W-1:0]    func,
	input  logic [gmd_pkg::COORD_W-1:0]   cell_row,
	input  logic [gmd_pkg::COORD_W-1:0]   cell_col,
	input  logic                          cell_blocked,
	input  logic [gmd_pkg::COORD_W-1:0]   start_row,
	input  logic [gmd_pkg::COORD_W-1:0]   start_col,
	input  logic [gmd_pkg::COORD_W-1:0]   target_row,
	input  logic [gmd_pkg::COORD_W-1:0]   target_col,
	input  logic [gmd_pkg::IDX_W-1:0]     path_index,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          found,
	output logic [gmd_pkg::LEN_W-1:0]     path_length,
	output logic [gmd_pkg::COORD_W-1:0]   step_row,
	output logic [gmd_pkg::COORD_W-1:0]   step_col,
	output logic                          index_valid
);
	import gmd_pkg::*;

	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CW    = $clog2(MAX_COLS);
	localparam int AW    = RW + CW;
	localparam int DEPTH = MAX_ROWS << CW;
	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int SAW   = $clog2(CELLS);
	localparam int CNTW  = $clog2(CELLS + 1);

	gmd_state_t state_q, state_d;

	logic [GRID_W-1:0]  grid_rows_q, grid_cols_q;
	logic [COORD_W-1:0] srow_q, scol_q, trow_q, tcol_q;
	logic               pend_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [AW-1:0]      sweep_q;
	logic               found_q;
	logic [CNTW-1:0]    count_q;
	logic [RW-1:0]      top_row_q, nbr_row_q;
	logic [CW-1:0]      top_col_q, nbr_col_q;
	logic [DIR_W-1:0]   dir_q;
	logic               start_blk_q;
	logic               path_ok_q;

	logic               out_valid_q, found_out_q, index_valid_q;
	logic [LEN_W-1:0]   length_q;
	logic [COORD_W-1:0] step_row_q, step_col_q;

	// Memory ports
	cell_ctl_t          cell_ctl;
	logic [AW-1:0]      cell_waddr, cell_raddr;
	logic [EPOCH_W-1:0] visit_wdata, visit_rdata;
	logic               maze_rdata;
	stk_ctl_t           stk_ctl;
	logic [SAW-1:0]     pos_waddr, dir_waddr, stk_raddr;
	logic [RW-1:0]      pos_wrow, rd_row;
	logic [CW-1:0]      pos_wcol, rd_col;
	logic [DIR_W-1:0]   dir_wdata, rd_dir;

	// Derived conditions
	logic [DIM_W-1:0]   rows_used, cols_used;
	logic               accept, ends_bad, at_target, push, write_ok, read_ok;
	logic               res_load;
	logic [RW-1:0]      nbr_row;
	logic [CW-1:0]      nbr_col;
	logic               nbr_ok;
	logic [RW:0]        row_inc;
	logic [CW:0]        col_inc;
	logic [AW-1:0]      start_addr, target_addr, top_addr;

	gmd_cell_store #(.AW(AW), .DEPTH(DEPTH)) u_cells (
		.clk         (clk),
		.ctl         (cell_ctl),
		.waddr       (cell_waddr),
		.visit_wdata (visit_wdata),
		.raddr       (cell_raddr),
		.maze_rdata  (maze_rdata),
		.visit_rdata (visit_rdata)
	);

	gmd_path_stack #(.RW(RW), .CW(CW), .SAW(SAW), .CELLS(CELLS)) u_stack (
		.clk       (clk),
		.ctl       (stk_ctl),
		.pos_waddr (pos_waddr),
		.pos_wrow  (pos_wrow),
		.pos_wcol  (pos_wcol),
		.dir_waddr (dir_waddr),
		.dir_wdata (dir_wdata),
		.raddr     (stk_raddr),
		.rd_row    (rd_row),
		.rd_col    (rd_col),
		.rd_dir    (rd_dir)
	);

	// Clamp the grid to the store
	assign rows_used = (DIM_W'(grid_rows_q) > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS)
		: DIM_W'(grid_rows_q);
	assign cols_used = (DIM_W'(grid_cols_q) > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS)
		: DIM_W'(grid_cols_q);

	assign accept   = in_valid && in_ready;
	assign ends_bad = !(DIM_W'(srow_q) < rows_used) || !(DIM_W'(scol_q) < cols_used)
		|| !(DIM_W'(trow_q) < rows_used) || !(DIM_W'(tcol_q) < cols_used);
	assign write_ok = (DIM_W'(cell_row) < DIM_W'(MAX_ROWS))
		&& (DIM_W'(cell_col) < DIM_W'(MAX_COLS));
	assign read_ok  = found_q && (32'(path_index) < 32'(count_q))
		&& (32'(path_index) < CELLS);

	// A result is ready after a write or no-op item, a path read or a finished search
	assign res_load = (state_q == S_IDLE && accept && func != FUNC_SEARCH
		&& func != FUNC_READ) || state_q == S_PATH || state_q == S_DONE;

	assign start_addr  = {RW'(srow_q), CW'(scol_q)};
	assign target_addr = {RW'(trow_q), CW'(tcol_q)};
	assign at_target   = (top_row_q == RW'(trow_q)) && (top_col_q == CW'(tcol_q));
	assign push        = !maze_rdata && (visit_rdata != epoch_q)
		&& (count_q < CNTW'(CELLS));

	// Neighbor of the top entry in the current direction
	assign row_inc = {1'b0, top_row_q} + (RW+1)'(1);
	assign col_inc = {1'b0, top_col_q} + (CW+1)'(1);

	always_comb begin
		nbr_row = top_row_q;
		nbr_col = top_col_q;
		nbr_ok  = 1'b0;
		case (dir_q)
			DIR_EAST: begin
				nbr_col = CW'(col_inc);
				nbr_ok  = DIM_W'(col_inc) < cols_used;
			end
			DIR_SOUTH: begin
				nbr_row = RW'(row_inc);
				nbr_ok  = DIM_W'(row_inc) < rows_used;
			end
			DIR_WEST: begin
				nbr_col = top_col_q - CW'(1);
				nbr_ok  = top_col_q != '0;
			end
			DIR_NORTH: begin
				nbr_row = top_row_q - RW'(1);
				nbr_ok  = top_row_q != '0;
			end
			default: begin
				nbr_ok = 1'b0;
			end
		endcase
	end

	assign top_addr = {nbr_row, nbr_col};

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_SWEEP: begin
				if (sweep_q == AW'(DEPTH - 1)) begin
					state_d = pend_q ? S_BEGIN : S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept && func == FUNC_SEARCH) begin
					state_d = S_BEGIN;
				end else if (accept && func == FUNC_READ) begin
					state_d = S_PATH;
				end
			end
			S_PATH:   state_d = S_IDLE;
			S_BEGIN: begin
				if (epoch_q == '1) begin
					state_d = S_SWEEP;
				end else if (ends_bad) begin
					state_d = S_DONE;
				end else begin
					state_d = S_RD_TGT;
				end
			end
			S_RD_TGT: state_d = S_CHK;
			S_CHK:    state_d = (start_blk_q || maze_rdata) ? S_DONE : S_STEP;
			S_STEP: begin
				if (at_target) begin
					state_d = S_DONE;
				end else if (dir_q != DIR_DONE) begin
					state_d = nbr_ok ? S_PROBE : S_STEP;
				end else if (count_q == CNTW'(1)) begin
					state_d = S_DONE;
				end else begin
					state_d = S_POP;
				end
			end
			S_PROBE:  state_d = S_STEP;
			S_POP:    state_d = S_STEP;
			S_DONE:   state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Memory strobes and handshake outputs
	always_comb begin
		in_ready    = 1'b0;
		cell_ctl    = '0;
		cell_waddr  = '0;
		cell_raddr  = '0;
		visit_wdata = epoch_q;
		stk_ctl     = '0;
		pos_waddr   = '0;
		pos_wrow    = '0;
		pos_wcol    = '0;
		dir_waddr   = SAW'(count_q - CNTW'(1));
		dir_wdata   = dir_q;
		stk_raddr   = '0;
		case (state_q)
			S_SWEEP: begin
				cell_ctl.visit_we = 1'b1;
				cell_waddr        = sweep_q;
				visit_wdata       = '0;
			end
			S_IDLE: begin
				in_ready = !out_valid_q || out_ready;
				if (accept && func == FUNC_WRITE && write_ok) begin
					cell_ctl.maze_we   = 1'b1;
					cell_ctl.maze_wbit = cell_blocked;
					cell_waddr         = {RW'(cell_row), CW'(cell_col)};
				end
				stk_raddr = SAW'(path_index);
			end
			S_BEGIN:  cell_raddr = start_addr;
			S_RD_TGT: cell_raddr = target_addr;
			S_CHK: begin
				if (!(start_blk_q || maze_rdata)) begin
					cell_ctl.visit_we = 1'b1;
					cell_waddr        = start_addr;
					stk_ctl.pos_we    = 1'b1;
					pos_wrow          = RW'(srow_q);
					pos_wcol          = CW'(scol_q);
				end
			end
			S_STEP: begin
				cell_raddr = top_addr;
				stk_raddr  = SAW'(count_q - CNTW'(2));
			end
			S_PROBE: begin
				if (push) begin
					cell_ctl.visit_we = 1'b1;
					cell_waddr        = {nbr_row_q, nbr_col_q};
					stk_ctl.pos_we    = 1'b1;
					stk_ctl.dir_we    = 1'b1;
					pos_waddr         = SAW'(count_q);
					pos_wrow          = nbr_row_q;
					pos_wcol          = nbr_col_q;
				end
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign cfg_ready = 1'b1;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			grid_rows_q <= GRID_RESET;
			grid_cols_q <= GRID_RESET;
			pend_q      <= 1'b0;
			epoch_q     <= '0;
			sweep_q     <= '0;
			found_q     <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// Take register writes
			if (cfg_valid && cfg_index == REG_GRID_ROWS) begin
				grid_rows_q <= cfg_data;
			end
			if (cfg_valid && cfg_index == REG_GRID_COLS) begin
				grid_cols_q <= cfg_data;
			end

			// Raise a new result, drop a delivered one
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_SWEEP: begin
					if (sweep_q == AW'(DEPTH - 1)) begin
						sweep_q <= '0;
						epoch_q <= '0;
					end else begin
						sweep_q <= sweep_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (accept && func == FUNC_SEARCH) begin
						pend_q <= 1'b1;
					end
				end
				S_BEGIN: begin
					found_q <= 1'b0;
					count_q <= '0;
					if (epoch_q != '1) begin
						epoch_q <= epoch_q + EPOCH_W'(1);
						pend_q  <= 1'b0;
					end
				end
				S_CHK: begin
					if (!(start_blk_q || maze_rdata)) begin
						count_q <= CNTW'(1);
					end
				end
				S_STEP: begin
					if (at_target) begin
						found_q <= 1'b1;
					end else if (dir_q == DIR_DONE) begin
						count_q <= count_q - CNTW'(1);
					end
				end
				S_PROBE: begin
					if (push) begin
						count_q <= count_q + CNTW'(1);
					end
				end
				default: begin
					pend_q <= pend_q;
				end
			endcase
		end
	end

	// Search and result datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					srow_q        <= start_row;
					scol_q        <= start_col;
					trow_q        <= target_row;
					tcol_q        <= target_col;
					path_ok_q     <= func == FUNC_READ && read_ok;
					found_out_q   <= found_q;
					length_q      <= found_q ? LEN_W'(count_q) : '0;
					step_row_q    <= '0;
					step_col_q    <= '0;
					index_valid_q <= 1'b0;
				end
			end
			S_PATH: begin
				index_valid_q <= path_ok_q;
				step_row_q    <= path_ok_q ? COORD_W'(rd_row) : '0;
				step_col_q    <= path_ok_q ? COORD_W'(rd_col) : '0;
			end
			S_RD_TGT: start_blk_q <= maze_rdata;
			S_CHK: begin
				top_row_q <= RW'(srow_q);
				top_col_q <= CW'(scol_q);
				dir_q     <= DIR_EAST;
			end
			S_STEP: begin
				if (!at_target && dir_q != DIR_DONE) begin
					dir_q     <= dir_q + DIR_W'(1);
					nbr_row_q <= nbr_row;
					nbr_col_q <= nbr_col;
				end
			end
			S_PROBE: begin
				if (push) begin
					top_row_q <= nbr_row_q;
					top_col_q <= nbr_col_q;
					dir_q     <= DIR_EAST;
				end
			end
			S_POP: begin
				top_row_q <= rd_row;
				top_col_q <= rd_col;
				dir_q     <= rd_dir;
			end
			S_DONE: begin
				found_out_q   <= found_q;
				length_q      <= found_q ? LEN_W'(count_q) : '0;
				step_row_q    <= '0;
				step_col_q    <= '0;
				index_valid_q <= 1'b0;
			end
			default: begin
				start_blk_q <= start_blk_q;
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign found       = found_out_q;
	assign path_length = length_q;
	assign step_row    = step_row_q;
	assign step_col    = step_col_q;
	assign index_valid = index_valid_q;

endmodule

@@ rtl/gmd_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks of the grid maze path search, bound to the top level.
// Depends on gmd_pkg.
module gmd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        found,
	input logic [gmd_pkg::LEN_W-1:0]   path_length,
	input logic [gmd_pkg::COORD_W-1:0] step_row,
	input logic [gmd_pkg::COORD_W-1:0] step_col,
	input logic                        index_valid
);
	import gmd_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(path_length) && $stable(found))
		else $error("result changed while stalled");

	// A valid path step needs a found path
	a_index_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && index_valid |-> found && path_length != '0)
		else $error("path step without a path");

	// No path length without a found path
	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> path_length == '0)
		else $error("path length without a found path");

	// Step fields stay zero unless the step is valid
	a_step_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !index_valid |-> step_row == '0 && step_col == '0)
		else $error("step fields set without a valid step");

endmodule

bind grid_maze_dfs_path_search gmd_checker u_gmd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.found       (found),
	.path_length (path_length),
	.step_row    (step_row),
	.step_col    (step_col),
	.index_valid (index_valid)
);
